>>> sv/tfe_pkg.sv
// ----------------------------------------------------------------------------
// tfe_pkg
// Types and constants shared by the three-floor elevator controller.
// ----------------------------------------------------------------------------
package tfe_pkg;

	// Configuration register indexes
	localparam int CfgIndexW = 2;
	localparam logic [CfgIndexW-1:0] CFG_DUTY_UP   = 2'd0;
	localparam logic [CfgIndexW-1:0] CFG_DUTY_DOWN = 2'd1;

	localparam logic [7:0] DUTY_UP_RST   = 8'd225;
	localparam logic [7:0] DUTY_DOWN_RST = 8'd190;

	// Item kinds
	localparam logic CMD_KEYPAD = 1'b0;
	localparam logic CMD_SENSOR = 1'b1;

	// Motor direction codes
	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd2;

	// Floor codes; zero means no floor seen yet
	localparam logic [1:0] FLOOR_NONE = 2'd0;
	localparam logic [1:0] FLOOR_1    = 2'd1;
	localparam logic [1:0] FLOOR_2    = 2'd2;
	localparam logic [1:0] FLOOR_3    = 2'd3;

	// Sensor readings: none, or exactly one bit set
	localparam logic [2:0] SENS_NONE = 3'b000;
	localparam logic [2:0] SENS_F1   = 3'b001;
	localparam logic [2:0] SENS_F2   = 3'b010;
	localparam logic [2:0] SENS_F3   = 3'b100;

	// Keypad codes (row bits 0-3, column bits 4-6)
	localparam logic [6:0] KEY_UP1   = 7'd18;
	localparam logic [6:0] KEY_UP2   = 7'd34;
	localparam logic [6:0] KEY_DOWN2 = 7'd66;
	localparam logic [6:0] KEY_CAR1  = 7'd20;
	localparam logic [6:0] KEY_CAR2  = 7'd36;
	localparam logic [6:0] KEY_CAR3  = 7'd68;
	localparam logic [6:0] KEY_DOWN3 = 7'd40;

	// Call flag masks
	localparam logic [6:0] F_CAR1  = 7'h01;
	localparam logic [6:0] F_CAR2  = 7'h02;
	localparam logic [6:0] F_CAR3  = 7'h04;
	localparam logic [6:0] F_UP1   = 7'h08;
	localparam logic [6:0] F_UP2   = 7'h10;
	localparam logic [6:0] F_DOWN2 = 7'h20;
	localparam logic [6:0] F_DOWN3 = 7'h40;

	// Controller state carried between items
	typedef struct packed {
		logic [6:0] call_flags;
		logic [1:0] goal_floor;
		logic [1:0] last_floor;
		logic [1:0] travel_dir;
		logic [7:0] duty_value;
	} ctrl_state_t;

	// Per-item status produced alongside the next state
	typedef struct packed {
		logic dwell;
		logic sensor_error;
	} step_flags_t;

endpackage

>>> sv/three_floor_elevator_fsm_unit.sv
// ----------------------------------------------------------------------------
// three_floor_elevator_fsm_unit
// Three-floor elevator controller: keypad calls, floor sensing, target and
// motor direction / duty selection, one result per event.
// ----------------------------------------------------------------------------
// One item is accepted every cycle while in_stall is low. The item is
// captured in an input register, and a single pass of the next-state logic
// then updates the controller state and loads the result register when the
// result register frees; a held result can delay this. The state feedback
// through that one pass of logic is what sets the rate of one item per cycle;
// a held result stalls the input once the input register is also full.
// Configuration writes are always ready and take effect on the next sensor
// event that sets an up or down direction.
module three_floor_elevator_fsm_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [6:0]                    key_code,
	input  logic [2:0]                    floor_sensors,
	// Result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    motor_dir,
	output logic [7:0]                    motor_duty,
	output logic [1:0]                    target_floor,
	output logic                          dwell,
	output logic                          sensor_error,
	output logic [6:0]                    pending,
	// Configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tfe_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);
	import tfe_pkg::*;

	logic        valid_s1;
	logic        cmd_s1;
	logic [6:0]  key_code_s1;
	logic [2:0]  floor_sensors_s1;
	logic        valid_s2;
	logic [7:0]  duty_up_q;
	logic [7:0]  duty_down_q;
	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	step_flags_t step_flags;
	logic        adv_s2;
	logic        adv_s1;

	// Flow control: result register frees when empty or being taken
	assign adv_s2    = !valid_s2 || !out_stall;
	assign in_stall  = valid_s1 && !adv_s2;
	assign adv_s1    = in_valid && !in_stall;
	assign out_valid = valid_s2;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_up_q   <= DUTY_UP_RST;
			duty_down_q <= DUTY_DOWN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DUTY_UP:   duty_up_q   <= cfg_data;
				CFG_DUTY_DOWN: duty_down_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s2 || !valid_s1) begin
			valid_s1 <= adv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			cmd_s1           <= cmd;
			key_code_s1      <= key_code;
			floor_sensors_s1 <= floor_sensors;
		end
	end

	// Next-state logic
	tfe_step u_step (
		.cmd           (cmd_s1),
		.key_code      (key_code_s1),
		.floor_sensors (floor_sensors_s1),
		.duty_up       (duty_up_q),
		.duty_down     (duty_down_q),
		.cur           (state_q),
		.nxt           (state_nxt),
		.flags         (step_flags)
	);

	// Controller state, updated as an item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.call_flags <= '0;
			state_q.goal_floor <= FLOOR_1;
			state_q.last_floor <= FLOOR_NONE;
			state_q.travel_dir <= DIR_STOP;
			state_q.duty_value <= DUTY_UP_RST;
			valid_s2           <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			motor_dir    <= state_nxt.travel_dir;
			motor_duty   <= state_nxt.duty_value;
			target_floor <= state_nxt.goal_floor;
			pending      <= state_nxt.call_flags;
			dwell        <= step_flags.dwell;
			sensor_error <= step_flags.sensor_error;
		end
	end

endmodule

>>> sv/tfe_step.sv
// ----------------------------------------------------------------------------
// tfe_step
// Next-state logic for one item: keypad latching, floor tracking and the
// floor service / target selection rules.
// ----------------------------------------------------------------------------
module tfe_step (
	input  logic                 cmd,
	input  logic [6:0]           key_code,
	input  logic [2:0]           floor_sensors,
	input  logic [7:0]           duty_up,
	input  logic [7:0]           duty_down,
	input  tfe_pkg::ctrl_state_t cur,
	output tfe_pkg::ctrl_state_t nxt,
	output tfe_pkg::step_flags_t flags
);
	import tfe_pkg::*;

	logic [6:0] cf;
	logic [1:0] floor;
	logic [1:0] goal;
	logic [1:0] dir;
	logic       served;
	logic       err;

	always_comb begin
		cf     = cur.call_flags;
		floor  = cur.last_floor;
		goal   = cur.goal_floor;
		dir    = cur.travel_dir;
		served = 1'b0;
		err    = 1'b0;

		if (cmd == CMD_KEYPAD) begin
			// Latch call flags from keypad
			case (key_code)
				KEY_UP1:   cf = cf | F_UP1;
				KEY_UP2:   cf = cf | F_UP2;
				KEY_DOWN2: cf = cf | F_DOWN2;
				KEY_CAR1:  cf = cf | F_CAR1;
				KEY_CAR2:  cf = cf | F_CAR2;
				KEY_CAR3:  cf = cf | F_CAR3;
				KEY_DOWN3: cf = cf | F_DOWN3;
				default:   cf = cf;
			endcase
		end else begin
			// Track last floor seen
			case (floor_sensors)
				SENS_NONE: floor = cur.last_floor;
				SENS_F1:   floor = FLOOR_1;
				SENS_F2:   floor = FLOOR_2;
				SENS_F3:   floor = FLOOR_3;
				default:   err   = 1'b1;
			endcase

			// Floor service and next target
			if (floor == FLOOR_1 && cur.goal_floor == FLOOR_1) begin
				served = 1'b1;
				cf = cf & ~(F_CAR1 | F_UP1);
				if ((cf & (F_CAR2 | F_UP2)) != '0) begin
					goal = FLOOR_2; dir = DIR_UP;
				end else if ((cf & (F_CAR3 | F_DOWN3)) != '0) begin
					goal = FLOOR_3; dir = DIR_UP;
				end else if ((cf & F_DOWN2) != '0) begin
					goal = FLOOR_2; dir = DIR_UP;
				end else begin
					dir = DIR_STOP;
				end
			end else if (floor == FLOOR_2 && (cur.goal_floor == FLOOR_2 ||
					(cf & (F_CAR2 | F_UP2 | F_DOWN2)) != '0)) begin
				served = 1'b1;
				cf = cf & ~F_CAR2;
				if ((cf & (F_CAR1 | F_UP1)) != '0 &&
						!((cf & F_DOWN3) != '0 && cur.travel_dir == DIR_UP)) begin
					goal = FLOOR_1; dir = DIR_DOWN;
					cf = cf & ~F_DOWN2;
				end else if ((cf & (F_CAR3 | F_DOWN3)) != '0 &&
						!((cf & F_UP1) != '0 && cur.travel_dir == DIR_DOWN)) begin
					goal = FLOOR_3; dir = DIR_UP;
					cf = cf & ~F_UP2;
				end else begin
					dir = DIR_STOP;
					cf = cf & ~(F_UP2 | F_DOWN2);
				end
			end else if (floor == FLOOR_3 && cur.goal_floor == FLOOR_3) begin
				served = 1'b1;
				cf = cf & ~(F_CAR3 | F_DOWN3);
				if ((cf & (F_CAR2 | F_DOWN2)) != '0) begin
					goal = FLOOR_2; dir = DIR_DOWN;
				end else if ((cf & (F_CAR1 | F_UP1)) != '0) begin
					goal = FLOOR_1; dir = DIR_DOWN;
				end else if ((cf & F_UP2) != '0) begin
					goal = FLOOR_2; dir = DIR_DOWN;
				end else begin
					dir = DIR_STOP;
				end
			end
		end
	end

	// Assemble next state; on sensor items duty follows direction, held when stopped
	always_comb begin
		nxt.call_flags = cf;
		nxt.goal_floor = goal;
		nxt.last_floor = floor;
		nxt.travel_dir = dir;
		nxt.duty_value = cur.duty_value;
		if (cmd == CMD_SENSOR) begin
			if (dir == DIR_UP) begin
				nxt.duty_value = duty_up;
			end else if (dir == DIR_DOWN) begin
				nxt.duty_value = duty_down;
			end
		end
		flags.dwell        = served;
		flags.sensor_error = err;
	end

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the three-floor elevator controller. A short
// scripted walk covers every call key, every sensor pattern and the
// floor-serving corner cases, then traffic that follows the car's travel is
// mixed with noise over several duty settings. Every accepted event is run
// through a behavioural copy of the controller and the result is compared
// field by field as it leaves the block, while both channels idle and stall
// at random.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tfe_pkg::*;

	localparam int CycleLimit = 300000;
	localparam int PhaseItems = 210;
	localparam int HoldCycles = 150;

	typedef struct packed {
		logic [1:0] motor_dir;
		logic [7:0] motor_duty;
		logic [1:0] target_floor;
		logic       dwell;
		logic       sensor_error;
		logic [6:0] pending;
	} floor_result_t;

	typedef struct packed {
		logic          cmd;
		logic [6:0]    key;
		logic [2:0]    sensors;
		logic          typed;
		floor_result_t res;
	} stim_row_t;

	localparam floor_result_t IdleAtReset = '{DIR_STOP, DUTY_UP_RST, FLOOR_1, 1'b0, 1'b0, 7'h00};
	localparam floor_result_t ErrAtReset  = '{DIR_STOP, DUTY_UP_RST, FLOOR_1, 1'b0, 1'b1, 7'h00};

	// Opening walk: reset values, key extremes, every call key, every sensor
	// pattern, floor-2 stop while bound elsewhere, floor seen but not served
	stim_row_t opening_rows [25] = '{
		'{CMD_KEYPAD, 7'd0,      3'd7,      1'b1, IdleAtReset},
		'{CMD_KEYPAD, 7'd127,    3'd0,      1'b1, IdleAtReset},
		'{CMD_SENSOR, 7'd127,    SENS_NONE, 1'b1, IdleAtReset},
		'{CMD_SENSOR, 7'd0,      3'b111,    1'b1, ErrAtReset},
		'{CMD_KEYPAD, KEY_UP2,   3'd0,      1'b0, '0},
		'{CMD_SENSOR, 7'd0,      SENS_F2,   1'b0, '0},
		'{CMD_KEYPAD, KEY_CAR3,  3'd5,      1'b0, '0},
		'{CMD_SENSOR, 7'd85,     SENS_F2,   1'b0, '0},
		'{CMD_SENSOR, 7'd42,     SENS_F1,   1'b0, '0},
		'{CMD_KEYPAD, KEY_CAR2,  3'd2,      1'b0, '0},
		'{CMD_KEYPAD, KEY_UP1,   3'd4,      1'b0, '0},
		'{CMD_SENSOR, 7'd0,      SENS_F2,   1'b0, '0},
		'{CMD_SENSOR, 7'd0,      3'b011,    1'b0, '0},
		'{CMD_SENSOR, 7'd0,      SENS_F1,   1'b0, '0},
		'{CMD_KEYPAD, KEY_DOWN3, 3'd1,      1'b0, '0},
		'{CMD_KEYPAD, KEY_UP2,   3'd6,      1'b0, '0},
		'{CMD_SENSOR, 7'd0,      SENS_NONE, 1'b0, '0},
		'{CMD_SENSOR, 7'd0,      SENS_F2,   1'b0, '0},
		'{CMD_SENSOR, 7'd0,      SENS_F3,   1'b0, '0},
		'{CMD_KEYPAD, KEY_DOWN2, 3'd0,      1'b0, '0},
		'{CMD_KEYPAD, KEY_CAR1,  3'd3,      1'b0, '0},
		'{CMD_SENSOR, 7'd0,      3'b101,    1'b0, '0},
		'{CMD_SENSOR, 7'd0,      SENS_F2,   1'b0, '0},
		'{CMD_SENSOR, 7'd0,      3'b110,    1'b0, '0},
		'{CMD_SENSOR, 7'd0,      SENS_F1,   1'b0, '0}
	};

	logic [6:0] call_keys [7] = '{KEY_UP1, KEY_UP2, KEY_DOWN2, KEY_CAR1, KEY_CAR2,
		KEY_CAR3, KEY_DOWN3};

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                cmd;
	logic [6:0]          key_code;
	logic [2:0]          floor_sensors;
	logic                out_valid;
	logic                out_stall;
	logic [1:0]          motor_dir;
	logic [7:0]          motor_duty;
	logic [1:0]          target_floor;
	logic                dwell;
	logic                sensor_error;
	logic [6:0]          pending;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIndexW-1:0] cfg_index;
	logic [7:0]          cfg_data;

	// Behavioural copy of the controller state and duty registers
	logic [6:0] car_calls;
	logic [1:0] car_goal;
	logic [1:0] car_floor;
	logic [1:0] car_dir;
	logic [7:0] car_duty;
	logic [7:0] duty_up_reg;
	logic [7:0] duty_down_reg;

	floor_result_t awaited_q [$];
	int            fail_count;
	int            burst_left;
	bit            hold_req;

	three_floor_elevator_fsm_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.key_code     (key_code),
		.floor_sensors(floor_sensors),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.motor_dir    (motor_dir),
		.motor_duty   (motor_duty),
		.target_floor (target_floor),
		.dwell        (dwell),
		.sensor_error (sensor_error),
		.pending      (pending),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic bit has_call(input logic [6:0] mask);
		return |(car_calls & mask);
	endfunction

	// Apply one event to the behavioural state and return the result it gives
	function automatic floor_result_t advance_car(input logic c, input logic [6:0] k,
		input logic [2:0] s);
		floor_result_t r;
		logic [1:0]    g;
		logic [1:0]    d;
		logic          served;
		logic          err;
		served = 1'b0;
		err    = 1'b0;
		if (c == CMD_KEYPAD) begin
			case (k)
				KEY_UP1:   car_calls |= F_UP1;
				KEY_UP2:   car_calls |= F_UP2;
				KEY_DOWN2: car_calls |= F_DOWN2;
				KEY_CAR1:  car_calls |= F_CAR1;
				KEY_CAR2:  car_calls |= F_CAR2;
				KEY_CAR3:  car_calls |= F_CAR3;
				KEY_DOWN3: car_calls |= F_DOWN3;
				default: ;
			endcase
		end else begin
			case (s)
				SENS_F1:   car_floor = FLOOR_1;
				SENS_F2:   car_floor = FLOOR_2;
				SENS_F3:   car_floor = FLOOR_3;
				SENS_NONE: ;
				default:   err = 1'b1;
			endcase
			g = car_goal;
			d = car_dir;
			if (car_floor == FLOOR_1 && car_goal == FLOOR_1) begin
				served = 1'b1;
				car_calls &= ~(F_CAR1 | F_UP1);
				if (has_call(F_CAR2 | F_UP2)) begin
					g = FLOOR_2; d = DIR_UP;
				end else if (has_call(F_CAR3 | F_DOWN3)) begin
					g = FLOOR_3; d = DIR_UP;
				end else if (has_call(F_DOWN2)) begin
					g = FLOOR_2; d = DIR_UP;
				end else begin
					d = DIR_STOP;
				end
			end else if (car_floor == FLOOR_2 &&
				(car_goal == FLOOR_2 || has_call(F_CAR2 | F_UP2 | F_DOWN2))) begin
				// floor 2 is served on the way past whenever it has a call
				served = 1'b1;
				car_calls &= ~F_CAR2;
				if (has_call(F_CAR1 | F_UP1) && !(has_call(F_DOWN3) && car_dir == DIR_UP)) begin
					g = FLOOR_1; d = DIR_DOWN;
					car_calls &= ~F_DOWN2;
				end else if (has_call(F_CAR3 | F_DOWN3) &&
					!(has_call(F_UP1) && car_dir == DIR_DOWN)) begin
					g = FLOOR_3; d = DIR_UP;
					car_calls &= ~F_UP2;
				end else begin
					d = DIR_STOP;
					car_calls &= ~(F_UP2 | F_DOWN2);
				end
			end else if (car_floor == FLOOR_3 && car_goal == FLOOR_3) begin
				served = 1'b1;
				car_calls &= ~(F_CAR3 | F_DOWN3);
				if (has_call(F_CAR2 | F_DOWN2)) begin
					g = FLOOR_2; d = DIR_DOWN;
				end else if (has_call(F_CAR1 | F_UP1)) begin
					g = FLOOR_1; d = DIR_DOWN;
				end else if (has_call(F_UP2)) begin
					g = FLOOR_2; d = DIR_DOWN;
				end else begin
					d = DIR_STOP;
				end
			end
			car_goal = g;
			car_dir  = d;
			// duty follows direction, held while stopped
			if (d == DIR_UP) car_duty = duty_up_reg;
			else if (d == DIR_DOWN) car_duty = duty_down_reg;
		end
		r.motor_dir    = car_dir;
		r.motor_duty   = car_duty;
		r.target_floor = car_goal;
		r.dwell        = served;
		r.sensor_error = err;
		r.pending      = car_calls;
		return r;
	endfunction

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// Offer one item in bursts; predict at the accepting edge
	task automatic send_item(input logic c, input logic [6:0] k, input logic [2:0] s,
		input logic typed, input floor_result_t typed_res);
		floor_result_t r;
		if (burst_left == 0) begin
			idle_cycles(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		in_valid      <= 1'b1;
		cmd           <= c;
		key_code      <= k;
		floor_sensors <= s;
		do @(posedge clk); while (in_stall);
		r = advance_car(c, k, s);
		awaited_q.push_back(typed ? typed_res : r);
	endtask

	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [7:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_DUTY_UP) duty_up_reg = value;
		else if (idx == CFG_DUTY_DOWN) duty_down_reg = value;
	endtask

	task automatic wait_drained();
		while (awaited_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_field(input string name, input int unsigned expv,
		input int unsigned actv);
		if (expv !== actv) begin
			$error("%s: expected %0d, actual %0d", name, expv, actv);
			fail_count++;
		end
	endtask

	// Result checker
	always @(posedge clk) begin
		floor_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_q.size() == 0) begin
				$error("result with no item outstanding");
				fail_count++;
			end else begin
				e = awaited_q.pop_front();
				check_field("motor_dir", e.motor_dir, motor_dir);
				check_field("motor_duty", e.motor_duty, motor_duty);
				check_field("target_floor", e.target_floor, target_floor);
				check_field("dwell", e.dwell, dwell);
				check_field("sensor_error", e.sensor_error, sensor_error);
				check_field("pending", e.pending, pending);
			end
		end
	end

	// Result side: segments of free flow, light and heavy stall, plus hold-offs
	initial begin
		int unsigned seg;
		int unsigned mode;
		int          hold_left;
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			seg  = $urandom_range(4, 40);
			mode = $urandom_range(0, 3);
			repeat (seg) begin
				@(negedge clk);
				if (hold_req) begin
					hold_req  = 1'b0;
					hold_left = HoldCycles;
				end
				if (hold_left > 0) begin
					hold_left--;
					out_stall <= 1'b1;
				end else begin
					case (mode)
						1:       out_stall <= ($urandom_range(0, 3) == 0);
						2:       out_stall <= ($urandom_range(0, 3) != 0);
						default: out_stall <= 1'b0;
					endcase
				end
			end
		end
	end

	// Watchdog
	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	// Main sequence
	initial begin
		logic       c;
		logic [6:0] k;
		logic [2:0] s;
		logic [1:0] next_floor;
		int unsigned pick;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		cmd           = CMD_KEYPAD;
		key_code      = '0;
		floor_sensors = SENS_NONE;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_DUTY_UP;
		cfg_data      = '0;
		fail_count    = 0;
		burst_left    = 0;
		hold_req      = 1'b0;
		car_calls     = '0;
		car_goal      = FLOOR_1;
		car_floor     = FLOOR_NONE;
		car_dir       = DIR_STOP;
		car_duty      = DUTY_UP_RST;
		duty_up_reg   = DUTY_UP_RST;
		duty_down_reg = DUTY_DOWN_RST;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// scripted walk at reset duty settings
		foreach (opening_rows[i])
			send_item(opening_rows[i].cmd, opening_rows[i].key, opening_rows[i].sensors,
				opening_rows[i].typed, opening_rows[i].res);

		for (int p = 0; p < 5; p++) begin
			// sender holds off until the block has emptied, then reprograms duty
			idle_cycles(1);
			wait_drained();
			case (p)
				0: begin
					write_reg(CFG_DUTY_UP, 8'hFF);
					write_reg(CFG_DUTY_DOWN, 8'h00);
				end
				1: begin
					write_reg(CFG_DUTY_UP, 8'h00);
					write_reg(CFG_DUTY_DOWN, 8'hFF);
				end
				2: begin
					write_reg(CFG_DUTY_DOWN, 8'($urandom));
					write_reg(CFG_DUTY_UP, 8'($urandom));
				end
				3: write_reg(CFG_DUTY_DOWN, 8'($urandom));
				default: begin
					write_reg(CFG_DUTY_UP, DUTY_UP_RST);
					write_reg(CFG_DUTY_DOWN, DUTY_DOWN_RST);
				end
			endcase
			@(negedge clk);
			cfg_valid <= 1'b0;
			if (p == 0 || p == 3) hold_req = 1'b1;

			for (int n = 0; n < PhaseItems; n++) begin
				pick = $urandom_range(0, 99);
				k    = 7'($urandom);
				s    = 3'($urandom);
				if (pick < 35) begin
					// passenger call
					c = CMD_KEYPAD;
					k = call_keys[$urandom_range(0, 6)];
				end else if (pick < 65) begin
					// sensor reading that follows the car's travel
					c = CMD_SENSOR;
					case (car_dir)
						DIR_UP:   next_floor = (car_floor == FLOOR_3) ? FLOOR_3 : car_floor + 2'd1;
						DIR_DOWN: next_floor = (car_floor <= FLOOR_1) ? FLOOR_1 : car_floor - 2'd1;
						default:  next_floor = (car_floor == FLOOR_NONE) ? FLOOR_1 : car_floor;
					endcase
					case (next_floor)
						FLOOR_1: s = SENS_F1;
						FLOOR_2: s = SENS_F2;
						default: s = SENS_F3;
					endcase
				end else if (pick < 75) begin
					// between floors
					c = CMD_SENSOR;
					s = SENS_NONE;
				end else if (pick < 88) begin
					// arbitrary reading: jumps and multi-bit faults
					c = CMD_SENSOR;
				end else begin
					// stray keypad code
					c = CMD_KEYPAD;
				end
				send_item(c, k, s, 1'b0, '0);
			end
		end

		idle_cycles(1);
		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
